// File: rtl/multi_exponential_response_filter_assert.svh
// Assertion macros for the multi-exponential response filter.
// Needs clk and rst_n in the including module's scope.
`ifndef MULTI_EXPONENTIAL_RESPONSE_FILTER_ASSERT_SVH
`define MULTI_EXPONENTIAL_RESPONSE_FILTER_ASSERT_SVH

// same-cycle implication
`define MEF_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MEF_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/mef_pkg.sv
// Shared constants, register indexes and controller-to-datapath command type
// for the multi-exponential response filter. No dependencies.
package mef_pkg;

  localparam int BOXES_DEF      = 3;
  localparam int COEF_FRAC_DEF  = 16;

  localparam int FORCING_W      = 24;
  localparam int OFFSET_W       = 24;
  localparam int X_W            = FORCING_W + 1;
  localparam int DECAY_W        = 16;
  localparam int GAIN_W         = 17;
  localparam int ACC_W          = 40;
  localparam int RESP_W         = 32;

  localparam int CFG_INDEX_W    = 8;
  localparam int CFG_DATA_W     = 24;
  localparam int REG_BOXES      = 3;
  localparam int REG_DECAY0     = 0;
  localparam int REG_GAIN0      = REG_BOXES;
  localparam int REG_OFFSET     = 2 * REG_BOXES;

  // shared multiplier: accumulator split into 24-bit low and signed high part
  localparam int LO_W           = 24;
  localparam int MUL_A_W        = LO_W + 1;
  localparam int MUL_B_W        = GAIN_W + 1;
  localparam int PROD_W         = MUL_A_W + MUL_B_W;
  localparam int MACC_W         = ACC_W + DECAY_W + 2;
  localparam int SUM_W          = 64;

  typedef logic [2:0] add_op_t;
  localparam add_op_t ADD_NONE    = 3'd0;
  localparam add_op_t ADD_MACC_LO = 3'd1;
  localparam add_op_t ADD_MACC_HI = 3'd2;
  localparam add_op_t ADD_SUM_LO  = 3'd3;
  localparam add_op_t ADD_SUM_HI  = 3'd4;

  typedef struct packed {
    logic    load;
    logic    mul_en;
    logic    mul_hi;
    logic    mul_gain;
    add_op_t add_op;
    logic    upd;
    logic    fin;
  } cmd_t;

endpackage

// File: rtl/mef_ctrl.sv
// Sequencer for the filter: walks each box through the shared multiplier.
// Depends on mef_pkg and the assertion macro header.
`include "multi_exponential_response_filter_assert.svh"

module mef_ctrl
  import mef_pkg::*;
#(
  parameter int BOXES = BOXES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic                out_free,
  output cmd_t                cmd,
  output logic [((BOXES > 1) ? $clog2(BOXES) : 1)-1:0] box
);

  localparam int BOX_W = (BOXES > 1) ? $clog2(BOXES) : 1;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_D0   = 4'd1;
  localparam logic [3:0] S_D1   = 4'd2;
  localparam logic [3:0] S_D2   = 4'd3;
  localparam logic [3:0] S_UPD  = 4'd4;
  localparam logic [3:0] S_G0   = 4'd5;
  localparam logic [3:0] S_G1   = 4'd6;
  localparam logic [3:0] S_G2   = 4'd7;
  localparam logic [3:0] S_FIN  = 4'd8;

  logic [3:0]       state_r, state_nxt;
  logic [BOX_W-1:0] box_r, box_nxt;
  logic             last_box;

  assign last_box  = (box_r == BOX_W'(BOXES - 1));
  assign in_tready = (state_r == S_IDLE);
  assign box       = box_r;

  always_comb begin
    state_nxt    = state_r;
    box_nxt      = box_r;
    cmd          = '0;
    cmd.add_op   = ADD_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          box_nxt   = '0;
          state_nxt = S_D0;
        end
      end
      S_D0: begin
        cmd.mul_en = 1'b1;
        state_nxt  = S_D1;
      end
      S_D1: begin
        cmd.mul_en = 1'b1;
        cmd.mul_hi = 1'b1;
        cmd.add_op = ADD_MACC_LO;
        state_nxt  = S_D2;
      end
      S_D2: begin
        cmd.add_op = ADD_MACC_HI;
        state_nxt  = S_UPD;
      end
      S_UPD: begin
        cmd.upd   = 1'b1;
        state_nxt = S_G0;
      end
      S_G0: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_gain = 1'b1;
        state_nxt    = S_G1;
      end
      S_G1: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_gain = 1'b1;
        cmd.mul_hi   = 1'b1;
        cmd.add_op   = ADD_SUM_LO;
        state_nxt    = S_G2;
      end
      S_G2: begin
        cmd.add_op = ADD_SUM_HI;
        if (last_box) begin
          state_nxt = S_FIN;
        end else begin
          box_nxt   = box_r + BOX_W'(1);
          state_nxt = S_D0;
        end
      end
      S_FIN: begin
        if (out_free) begin
          cmd.fin   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      box_r   <= '0;
    end else begin
      state_r <= state_nxt;
      box_r   <= box_nxt;
    end
  end

  `MEF_ASSERT_NXT(a_load_starts_box0, cmd.load, (state_r == S_D0) && (box_r == '0), "load must start at box 0")
  `MEF_ASSERT_IMP(a_fin_needs_slot, cmd.fin, out_free, "result issued into a full output slot")
  `MEF_ASSERT_IMP(a_box_in_range, state_r != S_IDLE, box_r <= BOX_W'(BOXES - 1), "box index out of range")

endmodule

// File: rtl/mef_dp.sv
// Datapath: accumulator bank, shared 25x18 multiplier, rounding, clipping and
// the output register. Depends on mef_pkg and the assertion macro header.
`include "multi_exponential_response_filter_assert.svh"

module mef_dp
  import mef_pkg::*;
#(
  parameter int BOXES          = BOXES_DEF,
  parameter int COEF_FRAC_BITS = COEF_FRAC_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  cmd_t                              cmd,
  input  logic [((BOXES > 1) ? $clog2(BOXES) : 1)-1:0] box,
  input  logic signed [FORCING_W-1:0]       forcing,
  input  logic                              start_series,
  input  logic [BOXES-1:0][DECAY_W-1:0]     decay,
  input  logic [BOXES-1:0][GAIN_W-1:0]      gain,
  input  logic signed [OFFSET_W-1:0]        forcing_offset,
  input  logic                              out_ready,
  output logic                              out_free,
  output logic                              out_valid,
  output logic signed [RESP_W-1:0]          response,
  output logic                              saturated
);

  localparam int BOX_W  = (BOXES > 1) ? $clog2(BOXES) : 1;
  localparam int HI_W   = ACC_W - LO_W;
  localparam logic signed [MACC_W-1:0] RND_M   = MACC_W'(1) <<< (COEF_FRAC_BITS - 1);
  localparam logic signed [SUM_W-1:0]  RND_S   = SUM_W'(1) <<< (COEF_FRAC_BITS - 1);
  localparam logic signed [MACC_W-1:0] ACC_MAX = (MACC_W'(1) <<< (ACC_W - 1)) - MACC_W'(1);
  localparam logic signed [MACC_W-1:0] ACC_MIN = -ACC_MAX - MACC_W'(1);
  localparam logic signed [SUM_W-1:0]  OUT_MAX = (SUM_W'(1) <<< (RESP_W - 1)) - SUM_W'(1);
  localparam logic signed [SUM_W-1:0]  OUT_MIN = -OUT_MAX - SUM_W'(1);

  logic signed [ACC_W-1:0]   acc_r [BOXES];
  logic signed [X_W-1:0]     x_r;
  logic signed [PROD_W-1:0]  p_r;
  logic signed [MACC_W-1:0]  macc_r;
  logic signed [SUM_W-1:0]   sum_r;
  logic                      sat_r;
  logic                      out_valid_r;
  logic signed [RESP_W-1:0]  out_data_r;
  logic                      out_sat_r;

  logic signed [ACC_W-1:0]   acc_cur;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod;
  logic signed [MACC_W-1:0]  p_m;
  logic signed [SUM_W-1:0]   p_s;
  logic signed [MACC_W-1:0]  dec_m;
  logic signed [MACC_W-1:0]  upd_m;
  logic signed [ACC_W-1:0]   acc_new;
  logic                      acc_clip;
  logic signed [SUM_W-1:0]   res_s;
  logic signed [RESP_W-1:0]  res_new;
  logic                      res_clip;

  assign acc_cur = acc_r[box];
  assign mul_a   = cmd.mul_hi
                 ? {{(MUL_A_W - HI_W){acc_cur[ACC_W-1]}}, acc_cur[ACC_W-1:LO_W]}
                 : {{(MUL_A_W - LO_W){1'b0}}, acc_cur[LO_W-1:0]};
  assign mul_b   = cmd.mul_gain
                 ? {{(MUL_B_W - GAIN_W){1'b0}}, gain[box]}
                 : {{(MUL_B_W - DECAY_W){1'b0}}, decay[box]};
  assign prod    = mul_a * mul_b;

  assign p_m = {{(MACC_W - PROD_W){p_r[PROD_W-1]}}, p_r};
  assign p_s = {{(SUM_W - PROD_W){p_r[PROD_W-1]}}, p_r};

  always_comb begin
    dec_m    = (macc_r + RND_M) >>> COEF_FRAC_BITS;
    upd_m    = dec_m + {{(MACC_W - X_W){x_r[X_W-1]}}, x_r};
    acc_clip = 1'b1;
    if (upd_m > ACC_MAX) begin
      acc_new = ACC_MAX[ACC_W-1:0];
    end else if (upd_m < ACC_MIN) begin
      acc_new = ACC_MIN[ACC_W-1:0];
    end else begin
      acc_new  = upd_m[ACC_W-1:0];
      acc_clip = 1'b0;
    end
  end

  always_comb begin
    res_s    = (sum_r + RND_S) >>> COEF_FRAC_BITS;
    res_clip = 1'b1;
    if (res_s > OUT_MAX) begin
      res_new = OUT_MAX[RESP_W-1:0];
    end else if (res_s < OUT_MIN) begin
      res_new = OUT_MIN[RESP_W-1:0];
    end else begin
      res_new  = res_s[RESP_W-1:0];
      res_clip = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      p_r <= prod;
    end
    if (cmd.load) begin
      x_r   <= {forcing[FORCING_W-1], forcing}
             + {{(X_W - OFFSET_W){forcing_offset[OFFSET_W-1]}}, forcing_offset};
      sum_r <= '0;
    end else begin
      unique case (cmd.add_op)
        ADD_MACC_LO: macc_r <= p_m;
        ADD_MACC_HI: macc_r <= macc_r + (p_m <<< LO_W);
        ADD_SUM_LO:  sum_r  <= sum_r + p_s;
        ADD_SUM_HI:  sum_r  <= sum_r + (p_s <<< LO_W);
        default: begin
        end
      endcase
    end
    if (cmd.fin) begin
      out_data_r <= res_new;
      out_sat_r  <= sat_r | res_clip;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < BOXES; i++) begin
        acc_r[i] <= '0;
      end
      sat_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      for (int i = 0; i < BOXES; i++) begin
        if (cmd.load && start_series) begin
          acc_r[i] <= '0;
        end else if (cmd.upd && (box == BOX_W'(i))) begin
          acc_r[i] <= acc_new;
        end
      end
      if (cmd.load) begin
        sat_r <= 1'b0;
      end else if (cmd.upd && acc_clip) begin
        sat_r <= 1'b1;
      end
      if (cmd.fin) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign response  = out_data_r;
  assign saturated = out_sat_r;

  `MEF_ASSERT_NXT(a_fin_sets_valid, cmd.fin, out_valid_r, "result not presented after finish")
  `MEF_ASSERT_NXT(a_load_clears_sat, cmd.load, !sat_r, "clip flag not cleared at load")
  `MEF_ASSERT_NXT(a_start_clears_acc, cmd.load && start_series, acc_r[0] == '0, "start did not clear accumulators")

endmodule

// File: rtl/multi_exponential_response_filter.sv
// Top level of the multi-exponential response filter: configuration registers
// and the stream ports. Depends on mef_pkg, mef_ctrl and mef_dp.
//
// Bank of first-order recursive filters sharing one 25x18 multiplier. Each box
// is walked through states: two multiplier passes for the decay product (low and
// high accumulator halves), one to merge the partial products, a round/add/clip
// update, two passes for the gain product and one to add the last partial
// product. A finish state then rounds and clips the response. The controller
// returns to idle between requests, and a request is accepted only in idle. One
// request is in flight at a time; a finished result sits in an output register so
// the next request is accepted while it waits, and a result that finds that
// register still full waits in the finish state until it is free or being read.
// Configuration is written through the cfg_ port, always ready, and must only
// change while the filter is idle.
module multi_exponential_response_filter
  import mef_pkg::*;
#(
  parameter int BOXES          = BOXES_DEF,
  parameter int COEF_FRAC_BITS = COEF_FRAC_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [FORCING_W-1:0]   in_tdata,   // [23:0] forcing
  input  logic                   in_tuser,   // [0] start_series
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [RESP_W-1:0]      out_tdata,  // [31:0] response
  output logic                   out_tuser,  // [0] saturated
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int BOX_W = (BOXES > 1) ? $clog2(BOXES) : 1;

  logic [BOXES-1:0][DECAY_W-1:0] decay_r;
  logic [BOXES-1:0][GAIN_W-1:0]  gain_r;
  logic signed [OFFSET_W-1:0]    offset_r;

  cmd_t                          cmd;
  logic [BOX_W-1:0]              box;
  logic                          out_free;
  logic signed [RESP_W-1:0]      response;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decay_r  <= '0;
      gain_r   <= '0;
      offset_r <= '0;
    end else if (cfg_valid) begin
      for (int b = 0; b < BOXES; b++) begin
        if (b < REG_BOXES) begin
          if (cfg_index == CFG_INDEX_W'(REG_DECAY0 + b)) begin
            decay_r[b] <= cfg_data[DECAY_W-1:0];
          end
          if (cfg_index == CFG_INDEX_W'(REG_GAIN0 + b)) begin
            gain_r[b] <= cfg_data[GAIN_W-1:0];
          end
        end
      end
      if (cfg_index == CFG_INDEX_W'(REG_OFFSET)) begin
        offset_r <= cfg_data[OFFSET_W-1:0];
      end
    end
  end

  mef_ctrl #(
    .BOXES(BOXES)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .out_free (out_free),
    .cmd      (cmd),
    .box      (box)
  );

  mef_dp #(
    .BOXES         (BOXES),
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .box           (box),
    .forcing       (in_tdata),
    .start_series  (in_tuser),
    .decay         (decay_r),
    .gain          (gain_r),
    .forcing_offset(offset_r),
    .out_ready     (out_tready),
    .out_free      (out_free),
    .out_valid     (out_tvalid),
    .response      (response),
    .saturated     (out_tuser)
  );

  assign out_tdata = response;

endmodule

// File: verif/multi_exponential_response_filter_tb.sv
// Self-checking testbench for multi_exponential_response_filter: directed table,
// then random phases checked against a predictor.
// Depends on mef_pkg and the filter RTL.
`timescale 1ns / 1ps

module multi_exponential_response_filter_tb;
  import mef_pkg::*;

  localparam longint ACC_HI   = (64'sd1 <<< (ACC_W - 1)) - 1;
  localparam longint ACC_LO   = -ACC_HI - 1;
  localparam longint RESP_HI  = (64'sd1 <<< (RESP_W - 1)) - 1;
  localparam longint RESP_LO  = -RESP_HI - 1;
  localparam longint HALF_LSB = 64'sd1 <<< (COEF_FRAC_DEF - 1);
  localparam int     GAIN_ONE = 1 << COEF_FRAC_DEF;

  typedef struct packed {
    logic [RESP_W-1:0] response;
    logic              saturated;
  } filter_result_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  // value holds the forcing sample for items, the write data for registers
  typedef struct packed {
    row_kind_t              kind;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  value;
    logic                   start;
    logic                   typed;
    filter_result_t         result;
  } stim_row_t;

  logic                   clk;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [FORCING_W-1:0]   in_tdata   = '0;
  logic                   in_tuser   = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [RESP_W-1:0]      out_tdata;
  logic                   out_tuser;
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index  = '0;
  logic [CFG_DATA_W-1:0]  cfg_data   = '0;

  // shadow of the filter's registers and state
  logic [DECAY_W-1:0]      decay_reg [BOXES_DEF];
  logic [GAIN_W-1:0]       gain_reg  [BOXES_DEF];
  logic signed [OFFSET_W-1:0] offset_reg;
  logic signed [ACC_W-1:0] bank_acc  [BOXES_DEF];

  filter_result_t expected_responses[$];
  int             mismatch_count = 0;
  int             stall_mode = 0;
  int             mode_cycles = 0;
  int             stall_left = 0;

  multi_exponential_response_filter dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #25_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("%0t ns mismatch: %s", $realtime, what);
  endtask

  // one filter step: decay and add per box, then weighted sum, all rounded half up
  function automatic filter_result_t step_bank(input logic [FORCING_W-1:0] forcing,
                                               input logic start);
    filter_result_t r;
    longint x, acc, sum;
    r.saturated = 1'b0;
    sum = 0;
    x = longint'($signed(forcing)) + longint'(offset_reg);
    for (int b = 0; b < BOXES_DEF; b++) begin
      acc = start ? 64'sd0 : longint'(bank_acc[b]);
      acc = ((acc * longint'(decay_reg[b]) + HALF_LSB) >>> COEF_FRAC_DEF) + x;
      if (acc > ACC_HI) begin
        acc = ACC_HI;
        r.saturated = 1'b1;
      end else if (acc < ACC_LO) begin
        acc = ACC_LO;
        r.saturated = 1'b1;
      end
      bank_acc[b] = acc[ACC_W-1:0];
      sum += acc * longint'(gain_reg[b]);
    end
    sum = (sum + HALF_LSB) >>> COEF_FRAC_DEF;
    if (sum > RESP_HI) begin
      sum = RESP_HI;
      r.saturated = 1'b1;
    end else if (sum < RESP_LO) begin
      sum = RESP_LO;
      r.saturated = 1'b1;
    end
    r.response = sum[RESP_W-1:0];
    return r;
  endfunction

  function automatic stim_row_t item_row(input logic [FORCING_W-1:0] forcing,
                                         input logic start, input logic typed,
                                         input logic [RESP_W-1:0] response,
                                         input logic saturated);
    stim_row_t r;
    r = '0;
    r.kind = ROW_ITEM;
    r.value = forcing;
    r.start = start;
    r.typed = typed;
    r.result.response = response;
    r.result.saturated = saturated;
    return r;
  endfunction

  function automatic stim_row_t cfg_row(input int index, input logic [CFG_DATA_W-1:0] value);
    stim_row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.index = CFG_INDEX_W'(index);
    r.value = value;
    return r;
  endfunction

  function automatic logic [FORCING_W-1:0] pick_forcing();
    case ($urandom_range(0, 3))
      0, 1:    return FORCING_W'($urandom);
      2:       return FORCING_W'($urandom_range(0, 8191) - 4096);
      default: return $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
    endcase
  endfunction

  function automatic logic [DECAY_W-1:0] pick_decay();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return '1;
      default: return DECAY_W'($urandom);
    endcase
  endfunction

  function automatic logic [GAIN_W-1:0] pick_gain();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return GAIN_W'(GAIN_ONE);
      default: return GAIN_W'($urandom_range(0, GAIN_ONE));
    endcase
  endfunction

  function automatic logic [OFFSET_W-1:0] pick_offset();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return 24'h7FFFFF;
      2:       return 24'h800000;
      default: return OFFSET_W'($urandom);
    endcase
  endfunction

  // valid is left high; the caller lowers it when the write group ends
  task automatic write_reg(input int index, input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_INDEX_W'(index);
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    if (index >= REG_DECAY0 && index < REG_DECAY0 + BOXES_DEF)
      decay_reg[index - REG_DECAY0] = value[DECAY_W-1:0];
    else if (index >= REG_GAIN0 && index < REG_GAIN0 + BOXES_DEF)
      gain_reg[index - REG_GAIN0] = value[GAIN_W-1:0];
    else if (index == REG_OFFSET)
      offset_reg = value[OFFSET_W-1:0];
  endtask

  task automatic push_item(input logic [FORCING_W-1:0] forcing, input logic start,
                           input logic typed, input filter_result_t typed_result);
    filter_result_t predicted;
    in_tvalid <= 1'b1;
    in_tdata  <= forcing;
    in_tuser  <= start;
    do @(posedge clk); while (!in_tready);
    predicted = step_bank(forcing, start);
    expected_responses.push_back(typed ? typed_result : predicted);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (expected_responses.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b1;
    end else begin
      if (mode_cycles == 0) begin
        stall_mode = $urandom_range(0, 2);
        mode_cycles = $urandom_range(50, 400);
      end else begin
        mode_cycles--;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        case (stall_mode)
          1: if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 4);
          2: if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(5, 40);
          default: ;
        endcase
      end
    end
  end

  always @(posedge clk) begin : response_check
    filter_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_responses.size() == 0) begin
        report_mismatch($sformatf("response %h with no request pending", out_tdata));
      end else begin
        want = expected_responses.pop_front();
        if (out_tdata !== want.response)
          report_mismatch($sformatf("response %h, predicted %h", out_tdata, want.response));
        if (out_tuser !== want.saturated)
          report_mismatch($sformatf("saturated %b, predicted %b", out_tuser, want.saturated));
      end
    end
  end

  initial begin : stimulus
    stim_row_t rows[$];
    int        start_odds;
    int        gap_max;
    int        burst_left;

    for (int b = 0; b < BOXES_DEF; b++) begin
      decay_reg[b] = '0;
      gain_reg[b]  = '0;
      bank_acc[b]  = '0;
    end
    offset_reg = '0;

    // registers at reset value: every gain is zero
    rows.push_back(item_row(24'h7FFFFF, 1'b1, 1'b1, 32'h0, 1'b0));
    rows.push_back(item_row(24'h800000, 1'b0, 1'b1, 32'h0, 1'b0));
    // box 0 passes the sample straight through; junk indexes ignored
    rows.push_back(cfg_row(REG_DECAY0, 24'h0));
    rows.push_back(cfg_row(REG_GAIN0, CFG_DATA_W'(GAIN_ONE)));
    rows.push_back(cfg_row(REG_OFFSET + 1, 24'hFFFFFF));
    rows.push_back(cfg_row(255, 24'h5A5A5A));
    rows.push_back(item_row(24'h000001, 1'b1, 1'b1, 32'h1, 1'b0));
    rows.push_back(item_row(24'h7FFFFF, 1'b0, 1'b1, 32'h007FFFFF, 1'b0));
    rows.push_back(item_row(24'h800000, 1'b0, 1'b1, 32'hFF800000, 1'b0));
    // half decay: rounding of exact halves on both signs
    rows.push_back(cfg_row(REG_DECAY0, 24'h8000));
    rows.push_back(item_row(24'hFFFFFF, 1'b1, 1'b1, 32'hFFFFFFFF, 1'b0));
    rows.push_back(item_row(24'h000000, 1'b0, 1'b1, 32'h0, 1'b0));
    rows.push_back(item_row(24'h000001, 1'b1, 1'b1, 32'h1, 1'b0));
    rows.push_back(item_row(24'h000000, 1'b0, 1'b1, 32'h1, 1'b0));
    rows.push_back(cfg_row(REG_GAIN0, 24'h8000));
    rows.push_back(item_row(24'hFFFFFF, 1'b1, 1'b1, 32'h0, 1'b0));
    rows.push_back(item_row(24'h000001, 1'b1, 1'b1, 32'h1, 1'b0));
    // decays and offset at their maxima, every gain at unity
    for (int b = 0; b < BOXES_DEF; b++) begin
      rows.push_back(cfg_row(REG_DECAY0 + b, 24'hFFFF));
      rows.push_back(cfg_row(REG_GAIN0 + b, CFG_DATA_W'(GAIN_ONE)));
    end
    rows.push_back(cfg_row(REG_OFFSET, 24'h7FFFFF));
    rows.push_back(item_row(24'h7FFFFF, 1'b1, 1'b1, 32'h02FFFFFA, 1'b0));
    rows.push_back(item_row(24'h7FFFFF, 1'b0, 1'b0, '0, 1'b0));
    rows.push_back(item_row(24'h000000, 1'b0, 1'b0, '0, 1'b0));
    rows.push_back(item_row(24'h800000, 1'b0, 1'b0, '0, 1'b0));
    rows.push_back(item_row(24'h123456, 1'b1, 1'b0, '0, 1'b0));
    // most negative offset, box 2 disabled by zero gain
    rows.push_back(cfg_row(REG_OFFSET, 24'h800000));
    rows.push_back(cfg_row(REG_GAIN0 + 2, 24'h0));
    rows.push_back(item_row(24'h800000, 1'b1, 1'b1, 32'hFE000000, 1'b0));
    rows.push_back(item_row(24'h7FFFFF, 1'b0, 1'b0, '0, 1'b0));
    rows.push_back(item_row(24'h5A5A5A, 1'b0, 1'b0, '0, 1'b0));

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_CFG) begin
        drain_results();
        write_reg(int'(rows[i].index), rows[i].value);
        if (i + 1 == rows.size() || rows[i + 1].kind != ROW_CFG) cfg_valid <= 1'b0;
      end else begin
        push_item(rows[i].value, rows[i].start, rows[i].typed, rows[i].result);
      end
    end

    // phase 0: max decay, unity gains, negative offset; phase 1: no memory, then random
    for (int phase = 0; phase < 6; phase++) begin
      drain_results();
      for (int b = 0; b < BOXES_DEF; b++) begin
        write_reg(REG_DECAY0 + b,
                  CFG_DATA_W'(phase == 0 ? 16'hFFFF : phase == 1 ? 16'h0 : pick_decay()));
        write_reg(REG_GAIN0 + b,
                  CFG_DATA_W'(phase < 2 ? GAIN_W'(GAIN_ONE) : pick_gain()));
      end
      write_reg(REG_OFFSET, phase == 0 ? 24'h800000 : phase == 1 ? 24'h7FFFFF : pick_offset());
      write_reg(int'($urandom_range(REG_OFFSET + 1, 255)), CFG_DATA_W'($urandom));
      cfg_valid <= 1'b0;
      start_odds = (phase == 0) ? 300 : $urandom_range(4, 40);
      gap_max = (phase == 2) ? 0 : $urandom_range(2, 30);
      burst_left = 0;
      repeat (320) begin
        if (burst_left == 0) begin
          if (gap_max != 0) begin
            in_tvalid <= 1'b0;
            repeat ($urandom_range(1, gap_max)) @(posedge clk);
          end
          burst_left = $urandom_range(1, 24);
        end
        push_item(pick_forcing(), $urandom_range(0, start_odds - 1) == 0, 1'b0, '0);
        burst_left--;
      end
    end

    drain_results();
    repeat (30) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
